>>> src/edc_pkg.sv
// ----------------------------------------------------------------------------
// edc_pkg
// shared types, constants and helpers for the edit distance engine
// ----------------------------------------------------------------------------
package edc_pkg;

  localparam int MAX_LEN = 64;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int SYM_W   = 8;
  localparam int DIST_W  = 16;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_FINISH = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SWEEP = 1'b1
  } state_t;

  // wavefront token handed from one cell to the next
  typedef struct packed {
    logic              valid;
    logic [SYM_W-1:0]  sym;
    logic [DIST_W-1:0] left;
  } edc_tok_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             restart;
    logic             wr_en;
    logic [LEN_W-1:0] wr_pos;
    logic [SYM_W-1:0] wr_sym;
  } edc_ctrl_t;

  // saturating increment
  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
    sat_inc = (v == {DIST_W{1'b1}}) ? v : v + DIST_W'(1);
  endfunction

endpackage

>>> src/edc_cell.sv
// ----------------------------------------------------------------------------
// edc_cell
// one column of the distance row: holds a reference symbol and one entry
// ----------------------------------------------------------------------------
module edc_cell
  import edc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [LEN_W-1:0]  idx,
  input  edc_ctrl_t         ctrl,
  input  edc_tok_t          tok_in,
  output edc_tok_t          tok_out,
  output logic [DIST_W-1:0] col_dist
);

  logic [SYM_W-1:0]  ref_sym;
  logic [DIST_W-1:0] diag;
  logic [DIST_W-1:0] up_inc;
  logic [DIST_W-1:0] left_inc;
  logic [DIST_W-1:0] sub;
  logic [DIST_W-1:0] best_a;
  logic [DIST_W-1:0] best_next;

  always_comb begin
    up_inc    = sat_inc(col_dist);
    left_inc  = sat_inc(tok_in.left);
    sub       = (ref_sym == tok_in.sym) ? diag : sat_inc(diag);
    best_a    = (left_inc < up_inc) ? left_inc : up_inc;
    best_next = (sub < best_a) ? sub : best_a;
  end

  // reference symbol, loaded when the append position matches this column
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (ctrl.wr_pos == idx - LEN_W'(1))) begin
      ref_sym <= ctrl.wr_sym;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.sym  <= tok_in.sym;
    tok_out.left <= best_next;
    if (rst || ctrl.restart) begin
      col_dist      <= DIST_W'(idx);
      diag          <= DIST_W'(idx - LEN_W'(1));
      tok_out.valid <= 1'b0;
    end else if (tok_in.valid) begin
      col_dist      <= best_next;
      diag          <= tok_in.left;
      tok_out.valid <= 1'b1;
    end else begin
      tok_out.valid <= 1'b0;
    end
  end

endmodule

>>> src/edit_distance_engine.sv
// ----------------------------------------------------------------------------
// edit_distance_engine
// levenshtein distance over a chain of cells, one column per reference symbol
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  request   req_valid / req_ready   action[1:0], symbol[7:0]
//  response  rsp_valid / rsp_ready   distance[15:0], truncated
//
//  clear, append and finish are taken in the idle state and start no sweep
//  a query symbol's wavefront walks the cell chain one column per cycle up to
//  the reference length, and the next transaction waits for it
//  finish is held off while an earlier result still sits in the output register
//  reset (rst, synchronous) empties the reference and sets entry j of the row to j
// ----------------------------------------------------------------------------
module edit_distance_engine
  import edc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        action,
  input  logic [SYM_W-1:0]  symbol,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [DIST_W-1:0] distance,
  output logic              truncated
);

  state_t            state, state_next;
  logic [LEN_W-1:0]  ref_len;
  logic [LEN_W-1:0]  cnt;
  logic              trunc_flag;
  logic [DIST_W-1:0] d0;
  edc_tok_t          tok0;
  edc_ctrl_t         ctrl;
  action_t           act;
  logic              accept;
  logic              slot_free;
  logic              len_full;

  // row entries: entry 0 lives here, entries 1..MAX_LEN in the cells
  logic [DIST_W-1:0] row [MAX_LEN+1];
  edc_tok_t          tok [MAX_LEN+1];

  assign act       = action_t'(action);
  assign slot_free = !rsp_valid || rsp_ready;
  assign len_full  = (ref_len >= LEN_W'(MAX_LEN));
  assign accept    = req_valid && req_ready;

  // next state and ready
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // finish needs room in the output register
        req_ready = (act != ACT_FINISH) || slot_free;
        if (accept && (act == ACT_QUERY) && (ref_len != '0)) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // last edge of the sweep updates the column at the reference length
        if (cnt == LEN_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // broadcast control: restart the query row, load a reference symbol
  always_comb begin
    ctrl.restart = accept && (act != ACT_QUERY);
    ctrl.wr_en   = accept && (act == ACT_APPEND) && !len_full;
    ctrl.wr_pos  = ref_len;
    ctrl.wr_sym  = symbol;
  end

  // sweep counter, loaded with the reference length when a query starts
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept && (act == ACT_QUERY)) begin
      cnt <= ref_len;
    end else if (state == ST_SWEEP) begin
      cnt <= cnt - LEN_W'(1);
    end
  end

  // reference length and sticky truncation
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_len    <= '0;
      trunc_flag <= 1'b0;
    end else if (accept) begin
      unique case (act)
        ACT_CLEAR: begin
          ref_len    <= '0;
          trunc_flag <= 1'b0;
        end
        ACT_APPEND: begin
          if (len_full) begin
            trunc_flag <= 1'b1;
          end else begin
            ref_len <= ref_len + LEN_W'(1);
          end
        end
        ACT_FINISH: trunc_flag <= 1'b0;
        ACT_QUERY:  ;
        default:    ;
      endcase
    end
  end

  // row entry 0 counts query symbols, and seeds the wavefront into column 1
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      d0 <= '0;
    end else if (accept && (act == ACT_QUERY)) begin
      d0 <= sat_inc(d0);
    end
  end

  always_ff @(posedge clk) begin
    tok0.sym  <= symbol;
    tok0.left <= sat_inc(d0);
    if (rst) begin
      tok0.valid <= 1'b0;
    end else begin
      tok0.valid <= accept && (act == ACT_QUERY);
    end
  end

  assign row[0] = d0;
  assign tok[0] = tok0;

  // the cell chain
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    edc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (LEN_W'(k + 1)),
      .ctrl     (ctrl),
      .tok_in   (tok[k]),
      .tok_out  (tok[k+1]),
      .col_dist (row[k+1])
    );
  end

  // output register, filled by a finish transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept && (act == ACT_FINISH)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (act == ACT_FINISH)) begin
      distance  <= row[ref_len];
      truncated <= trunc_flag;
    end
  end

  // the last chain token is unused past the final column
  logic unused_tail;
  assign unused_tail = ^tok[MAX_LEN];

endmodule
